@@ hw/rtl/multi_pattern_occurrence_counter_defines.svh @@
// Assertion helpers used by the checker file of this block.
`ifndef MULTI_PATTERN_OCCURRENCE_COUNTER_DEFINES_SVH
`define MULTI_PATTERN_OCCURRENCE_COUNTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MPOC_ASSERT_SAME(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MPOC_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/mpoc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mpoc_pkg;

	// Field widths of the transaction ports.
	localparam int CMD_W   = 2;
	localparam int SYM_W   = 5;
	localparam int PID_W   = 8;
	localparam int COUNT_W = 32;
	localparam int ST_W    = 2;

	localparam logic [COUNT_W-1:0] COUNT_OUT_MAX = 32'hFFFF_FFFF;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

	// Status codes.
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_NOPAT = 2'd2;
	localparam logic [ST_W-1:0] ST_PHASE = 2'd3;

	// Queue depths between the parts.
	localparam int CMDQ_DEPTH = 4;
	localparam int RESQ_DEPTH = 2;

	// A classified command as it travels from the front to the engine.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             sym_ok;
		logic             pid_ok;
		logic [SYM_W-1:0] symbol;
		logic             last;
		logic [PID_W-1:0] pattern_id;
	} mpoc_op_t;

	// One result transaction.
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [PID_W-1:0]   pattern_echo;
		logic [ST_W-1:0]    status;
	} mpoc_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/mpoc_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mpoc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CNTW-1:0]  cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNTW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/mpoc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mpoc_front #(
	parameter int ALPHABET     = 26,
	parameter int MAX_PATTERNS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [mpoc_pkg::CMD_W-1:0]   cmd,
	input  logic [mpoc_pkg::SYM_W-1:0]   symbol,
	input  logic                         last,
	input  logic [mpoc_pkg::PID_W-1:0]   pattern_id,
	input  logic                         hold,
	output logic                         op_valid,
	output mpoc_pkg::mpoc_op_t           op,
	input  logic                         op_pop
);

	import mpoc_pkg::*;

	mpoc_op_t op_in;
	logic     q_full;
	logic     q_empty;

	// Classify the operands once, so the engine only tests flags.
	always_comb begin
		op_in.cmd        = cmd;
		op_in.sym_ok     = (int'(symbol) < ALPHABET);
		op_in.pid_ok     = (int'(pattern_id) < MAX_PATTERNS);
		op_in.symbol     = symbol;
		op_in.last       = last;
		op_in.pattern_id = pattern_id;
	end

	// No transaction is taken while the engine sweeps its memories.
	assign full     = q_full || hold;
	assign op_valid = !q_empty;

	mpoc_fifo #(
		.WIDTH($bits(mpoc_op_t)),
		.DEPTH(CMDQ_DEPTH)
	) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && !full),
		.wdata (op_in),
		.full  (q_full),
		.pop   (op_pop),
		.rdata (op),
		.empty (q_empty)
	);

endmodule

`default_nettype wire

@@ hw/rtl/mpoc_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mpoc_engine #(
	parameter int MAX_NODES    = 4096,
	parameter int ALPHABET     = 26,
	parameter int MAX_PATTERNS = 256,
	parameter int COUNT_BITS   = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                op_valid,
	input  mpoc_pkg::mpoc_op_t  op,
	output logic                op_pop,
	input  logic                res_full,
	output logic                res_push,
	output mpoc_pkg::mpoc_res_t res,
	output logic                clearing
);

	import mpoc_pkg::*;

	localparam int NW      = $clog2(MAX_NODES);
	localparam int SW      = $clog2(ALPHABET);
	localparam int GW      = NW + SW;
	localparam int PW      = $clog2(MAX_PATTERNS);
	localparam int GD      = MAX_NODES * (2 ** SW);
	localparam int CLR_LEN = (GD > MAX_PATTERNS) ? GD : MAX_PATTERNS;
	localparam int CW      = $clog2(CLR_LEN);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	// Sequencer states.
	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_LD   = 4'd2;
	localparam logic [3:0] S_BC0  = 4'd3;
	localparam logic [3:0] S_BC1  = 4'd4;
	localparam logic [3:0] S_BC2  = 4'd5;
	localparam logic [3:0] S_BN0  = 4'd6;
	localparam logic [3:0] S_BN1  = 4'd7;
	localparam logic [3:0] S_BN2  = 4'd8;
	localparam logic [3:0] S_SC1  = 4'd9;
	localparam logic [3:0] S_SC2  = 4'd10;
	localparam logic [3:0] S_SC3  = 4'd11;
	localparam logic [3:0] S_SC4  = 4'd12;
	localparam logic [3:0] S_RD1  = 4'd13;
	localparam logic [3:0] S_RD2  = 4'd14;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] x);
		return (x == CNT_MAX) ? x : x + COUNT_BITS'(1);
	endfunction

	// Memories.
	logic [NW-1:0]         gt_mem [GD];
	logic [NW-1:0]         fl_mem [MAX_NODES];
	logic [NW-1:0]         dl_mem [MAX_NODES];
	logic                  we_mem [MAX_NODES];
	logic [COUNT_BITS-1:0] nc_mem [MAX_NODES];
	logic [NW-1:0]         pe_mem [MAX_PATTERNS];
	logic [NW-1:0]         q_mem  [MAX_NODES];

	// Registered read data.
	logic [NW-1:0]         gt_da_q, gt_db_q, fl_d_q, dl_d_q, pe_d_q, q_d_q;
	logic                  we_d_q;
	logic [COUNT_BITS-1:0] nc_d_q;

	// Port controls.
	logic [GW-1:0]         gt_ra, gt_rb, gt_wa;
	logic [NW-1:0]         fl_ra, dl_ra, we_ra, nc_ra, q_ra;
	logic [NW-1:0]         fl_wa, dl_wa, we_wa, nc_wa, q_wa;
	logic [PW-1:0]         pe_ra, pe_wa;
	logic                  gt_we, fl_we, dl_we, we_we, nc_we, pe_we, q_we;
	logic [NW-1:0]         gt_wd, fl_wd, dl_wd, pe_wd, q_wd;
	logic                  we_wd;
	logic [COUNT_BITS-1:0] nc_wd;

	// Control registers and their next values.
	logic [3:0]    state_q, state_d;
	logic [CW-1:0] clr_q, clr_d;
	logic          built_q, built_d;
	logic [NW-1:0] load_cur_q, load_cur_d;
	logic [NW-1:0] scan_cur_q, scan_cur_d;
	logic [NW:0]   nodes_used_q, nodes_used_d;
	logic          root_q, root_d;
	logic [SW-1:0] c_q, c_d;
	logic [NW-1:0] head_q, head_d;
	logic [NW-1:0] tail_q, tail_d;

	// Operand and work registers.
	logic [SW-1:0]    sym_q, sym_d;
	logic             last_q, last_d;
	logic [PID_W-1:0] pid_q, pid_d;
	logic             pid_ok_q, pid_ok_d;
	logic [NW-1:0]    u_q, u_d, fu_q, fu_d, v_q, v_d, f_q, f_d, k_q, k_d;

	logic [NW-1:0] cid;
	logic [NW-1:0] fval;
	logic [63:0]   nc_ext;

	assign clearing = (state_q == S_CLR);
	assign nc_ext   = 64'(nc_d_q);

	// Sequencer: one command at a time; memory reads are registered, so their data is used in the next state.
	always_comb begin
		state_d      = state_q;
		clr_d        = clr_q;
		built_d      = built_q;
		load_cur_d   = load_cur_q;
		scan_cur_d   = scan_cur_q;
		nodes_used_d = nodes_used_q;
		root_d       = root_q;
		c_d          = c_q;
		head_d       = head_q;
		tail_d       = tail_q;
		sym_d        = sym_q;
		last_d       = last_q;
		pid_d        = pid_q;
		pid_ok_d     = pid_ok_q;
		u_d          = u_q;
		fu_d         = fu_q;
		v_d          = v_q;
		f_d          = f_q;
		k_d          = k_q;
		cid          = '0;
		fval         = '0;
		op_pop       = 1'b0;
		res_push     = 1'b0;
		res          = '0;
		gt_ra = '0; gt_rb = '0; fl_ra = '0; dl_ra = '0; we_ra = '0;
		nc_ra = '0; q_ra = '0; pe_ra = '0;
		gt_we = 1'b0; gt_wa = '0; gt_wd = '0;
		fl_we = 1'b0; fl_wa = '0; fl_wd = '0;
		dl_we = 1'b0; dl_wa = '0; dl_wd = '0;
		we_we = 1'b0; we_wa = '0; we_wd = 1'b0;
		nc_we = 1'b0; nc_wa = '0; nc_wd = '0;
		pe_we = 1'b0; pe_wa = '0; pe_wd = '0;
		q_we  = 1'b0; q_wa  = '0; q_wd  = '0;

		unique case (state_q)
			S_CLR: begin
				// Zero every entry of the stores that reset clears.
				gt_we = (int'(clr_q) < GD);
				gt_wa = clr_q[GW-1:0];
				fl_we = (int'(clr_q) < MAX_NODES);
				fl_wa = clr_q[NW-1:0];
				dl_we = fl_we;
				dl_wa = clr_q[NW-1:0];
				we_we = fl_we;
				we_wa = clr_q[NW-1:0];
				nc_we = fl_we;
				nc_wa = clr_q[NW-1:0];
				pe_we = (int'(clr_q) < MAX_PATTERNS);
				pe_wa = clr_q[PW-1:0];
				clr_d = clr_q + 1'b1;
				if (int'(clr_q) == CLR_LEN - 1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				res.pattern_echo = op.pattern_id;
				if (op_valid && !res_full) begin
					op_pop   = 1'b1;
					sym_d    = SW'(op.symbol);
					last_d   = op.last;
					pid_d    = op.pattern_id;
					pid_ok_d = op.pid_ok;
					unique case (op.cmd)
						CMD_LOAD: begin
							gt_ra = {load_cur_q, SW'(op.symbol)};
							if (built_q) begin
								res_push   = 1'b1;
								res.status = ST_PHASE;
							end else if (!op.sym_ok) begin
								load_cur_d = '0;
								res_push   = 1'b1;
								res.status = ST_PHASE;
							end else begin
								state_d = S_LD;
							end
						end
						CMD_BUILD: begin
							if (built_q) begin
								res_push   = 1'b1;
								res.status = ST_PHASE;
							end else begin
								root_d  = 1'b1;
								u_d     = '0;
								fu_d    = '0;
								c_d     = '0;
								head_d  = '0;
								tail_d  = '0;
								state_d = S_BC0;
							end
						end
						CMD_SCAN: begin
							gt_ra = {scan_cur_q, SW'(op.symbol)};
							if (!built_q) begin
								res_push   = 1'b1;
								res.status = ST_PHASE;
							end else if (!op.sym_ok) begin
								scan_cur_d = '0;
							end else begin
								state_d = S_SC1;
							end
						end
						CMD_READ: begin
							pe_ra = PW'(op.pattern_id);
							if (!op.pid_ok) begin
								res_push   = 1'b1;
								res.status = ST_NOPAT;
							end else begin
								state_d = S_RD1;
							end
						end
					endcase
				end
			end
			S_LD: begin
				// Follow or create the child (or report full), then mark a word end on the last letter of a valid pattern id.
				res.pattern_echo = pid_q;
				state_d          = S_IDLE;
				if (gt_da_q == '0 && nodes_used_q == (NW + 1)'(MAX_NODES)) begin
					load_cur_d = '0;
					res_push   = 1'b1;
					res.status = ST_FULL;
				end else begin
					cid = (gt_da_q == '0) ? nodes_used_q[NW-1:0] : gt_da_q;
					if (gt_da_q == '0) begin
						gt_we        = 1'b1;
						gt_wa        = {load_cur_q, sym_q};
						gt_wd        = cid;
						nodes_used_d = nodes_used_q + 1'b1;
					end
					if (!last_q) begin
						load_cur_d = cid;
					end else begin
						load_cur_d = '0;
						res_push   = 1'b1;
						if (!pid_ok_q) begin
							res.status = ST_PHASE;
						end else begin
							we_we      = 1'b1;
							we_wa      = cid;
							we_wd      = 1'b1;
							pe_we      = 1'b1;
							pe_wa      = PW'(pid_q);
							pe_wd      = cid;
							res.status = ST_OK;
						end
					end
				end
			end
			S_BC0: begin
				gt_ra   = {u_q, c_q};
				gt_rb   = {fu_q, c_q};
				state_d = S_BC1;
			end
			S_BC1: begin
				// Children of the root fail to the root itself.
				fval = root_q ? '0 : gt_db_q;
				f_d  = fval;
				v_d  = gt_da_q;
				if (gt_da_q != '0) begin
					we_ra   = fval;
					dl_ra   = fval;
					state_d = S_BC2;
				end else begin
					if (!root_q) begin
						gt_we = 1'b1;
						gt_wa = {u_q, c_q};
						gt_wd = fval;
					end
					if (c_q == SW'(ALPHABET - 1)) begin
						root_d  = 1'b0;
						state_d = S_BN0;
					end else begin
						c_d     = c_q + 1'b1;
						state_d = S_BC0;
					end
				end
			end
			S_BC2: begin
				// Link the child and queue it for its own visit.
				fl_we  = 1'b1;
				fl_wa  = v_q;
				fl_wd  = f_q;
				dl_we  = 1'b1;
				dl_wa  = v_q;
				dl_wd  = we_d_q ? f_q : dl_d_q;
				q_we   = 1'b1;
				q_wa   = tail_q;
				q_wd   = v_q;
				tail_d = tail_q + 1'b1;
				if (c_q == SW'(ALPHABET - 1)) begin
					root_d  = 1'b0;
					state_d = S_BN0;
				end else begin
					c_d     = c_q + 1'b1;
					state_d = S_BC0;
				end
			end
			S_BN0: begin
				res.pattern_echo = pid_q;
				if (head_q == tail_q) begin
					built_d    = 1'b1;
					load_cur_d = '0;
					res_push   = 1'b1;
					res.status = ST_OK;
					state_d    = S_IDLE;
				end else begin
					q_ra    = head_q;
					head_d  = head_q + 1'b1;
					state_d = S_BN1;
				end
			end
			S_BN1: begin
				u_d     = q_d_q;
				fl_ra   = q_d_q;
				state_d = S_BN2;
			end
			S_BN2: begin
				fu_d    = fl_d_q;
				c_d     = '0;
				state_d = S_BC0;
			end
			S_SC1: begin
				k_d        = gt_da_q;
				we_ra      = gt_da_q;
				dl_ra      = gt_da_q;
				nc_ra      = gt_da_q;
				scan_cur_d = last_q ? '0 : gt_da_q;
				state_d    = S_SC2;
			end
			S_SC2: begin
				if (we_d_q) begin
					nc_we = 1'b1;
					nc_wa = k_q;
					nc_wd = sat_inc(nc_d_q);
				end
				if (dl_d_q != '0) begin
					k_d     = dl_d_q;
					state_d = S_SC3;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SC3: begin
				nc_ra   = k_q;
				dl_ra   = k_q;
				state_d = S_SC4;
			end
			S_SC4: begin
				// Every node on the dictionary chain is a word end.
				nc_we = 1'b1;
				nc_wa = k_q;
				nc_wd = sat_inc(nc_d_q);
				if (dl_d_q != '0) begin
					k_d     = dl_d_q;
					state_d = S_SC3;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_RD1: begin
				res.pattern_echo = pid_q;
				if (pe_d_q == '0) begin
					res_push   = 1'b1;
					res.status = ST_NOPAT;
					state_d    = S_IDLE;
				end else begin
					nc_ra   = pe_d_q;
					state_d = S_RD2;
				end
			end
			S_RD2: begin
				res_push         = 1'b1;
				res.pattern_echo = pid_q;
				res.status       = ST_OK;
				res.count        = (nc_ext[63:32] != '0) ? COUNT_OUT_MAX : nc_ext[31:0];
				state_d          = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_q        <= '0;
			built_q      <= 1'b0;
			load_cur_q   <= '0;
			scan_cur_q   <= '0;
			nodes_used_q <= (NW + 1)'(1);
			root_q       <= 1'b0;
			c_q          <= '0;
			head_q       <= '0;
			tail_q       <= '0;
		end else begin
			state_q      <= state_d;
			clr_q        <= clr_d;
			built_q      <= built_d;
			load_cur_q   <= load_cur_d;
			scan_cur_q   <= scan_cur_d;
			nodes_used_q <= nodes_used_d;
			root_q       <= root_d;
			c_q          <= c_d;
			head_q       <= head_d;
			tail_q       <= tail_d;
		end
	end

	// Operand and work registers.
	always_ff @(posedge clk) begin
		sym_q    <= sym_d;
		last_q   <= last_d;
		pid_q    <= pid_d;
		pid_ok_q <= pid_ok_d;
		u_q      <= u_d;
		fu_q     <= fu_d;
		v_q      <= v_d;
		f_q      <= f_d;
		k_q      <= k_d;
	end

	// Goto table: one write port, two read ports.
	always_ff @(posedge clk) begin
		if (gt_we) begin
			gt_mem[gt_wa] <= gt_wd;
		end
		gt_da_q <= gt_mem[gt_ra];
		gt_db_q <= gt_mem[gt_rb];
	end

	// Failure links.
	always_ff @(posedge clk) begin
		if (fl_we) begin
			fl_mem[fl_wa] <= fl_wd;
		end
		fl_d_q <= fl_mem[fl_ra];
	end

	// Dictionary links.
	always_ff @(posedge clk) begin
		if (dl_we) begin
			dl_mem[dl_wa] <= dl_wd;
		end
		dl_d_q <= dl_mem[dl_ra];
	end

	// Word-end flags.
	always_ff @(posedge clk) begin
		if (we_we) begin
			we_mem[we_wa] <= we_wd;
		end
		we_d_q <= we_mem[we_ra];
	end

	// Occurrence counts.
	always_ff @(posedge clk) begin
		if (nc_we) begin
			nc_mem[nc_wa] <= nc_wd;
		end
		nc_d_q <= nc_mem[nc_ra];
	end

	// Pattern end nodes.
	always_ff @(posedge clk) begin
		if (pe_we) begin
			pe_mem[pe_wa] <= pe_wd;
		end
		pe_d_q <= pe_mem[pe_ra];
	end

	// Breadth-first work queue.
	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_wa] <= q_wd;
		end
		q_d_q <= q_mem[q_ra];
	end

endmodule

`default_nettype wire

@@ hw/rtl/multi_pattern_occurrence_counter.sv @@
// Channel   Direction  Handshake                  Payload
// input     in         push / full  (push & !full)  cmd, symbol, last, pattern_id
// result    out        empty / pop  (pop & !empty)  count, pattern_echo, status
//
// A load letter reads the goto table, then follows or creates the child; a read
// looks up the pattern end node, then its count; a scan letter follows its goto
// entry, then every dictionary link on its chain. A command refused on its flags
// alone is handled in idle. Build visits every letter slot of every node in
// breadth-first order. Reset starts a clearing pass over max(MAX_NODES *
// 2**clog2(ALPHABET), MAX_PATTERNS) entries (131072 by default) with full held high.
// The command queue and result queue let either side stall on its own.
`timescale 1ns / 1ps
`default_nettype none

module multi_pattern_occurrence_counter #(
	parameter int MAX_NODES    = 4096,
	parameter int ALPHABET     = 26,
	parameter int MAX_PATTERNS = 256,
	parameter int COUNT_BITS   = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [mpoc_pkg::CMD_W-1:0]   cmd,
	input  logic [mpoc_pkg::SYM_W-1:0]   symbol,
	input  logic                         last,
	input  logic [mpoc_pkg::PID_W-1:0]   pattern_id,
	output logic                         empty,
	input  logic                         pop,
	output logic [mpoc_pkg::COUNT_W-1:0] count,
	output logic [mpoc_pkg::PID_W-1:0]   pattern_echo,
	output logic [mpoc_pkg::ST_W-1:0]    status
);

	import mpoc_pkg::*;

	logic      clearing;
	logic      op_valid;
	mpoc_op_t  op;
	logic      op_pop;
	logic      res_push;
	mpoc_res_t res;
	logic      res_full;
	mpoc_res_t res_out;

	// Front: takes and classifies transactions.
	mpoc_front #(
		.ALPHABET    (ALPHABET),
		.MAX_PATTERNS(MAX_PATTERNS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.symbol    (symbol),
		.last      (last),
		.pattern_id(pattern_id),
		.hold      (clearing),
		.op_valid  (op_valid),
		.op        (op),
		.op_pop    (op_pop)
	);

	// Back: trie, link build, scan and read.
	mpoc_engine #(
		.MAX_NODES   (MAX_NODES),
		.ALPHABET    (ALPHABET),
		.MAX_PATTERNS(MAX_PATTERNS),
		.COUNT_BITS  (COUNT_BITS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.op_valid(op_valid),
		.op      (op),
		.op_pop  (op_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res     (res),
		.clearing(clearing)
	);

	// Result queue.
	mpoc_fifo #(
		.WIDTH($bits(mpoc_res_t)),
		.DEPTH(RESQ_DEPTH)
	) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign count        = res_out.count;
	assign pattern_echo = res_out.pattern_echo;
	assign status       = res_out.status;

endmodule

`default_nettype wire

@@ hw/rtl/mpoc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "multi_pattern_occurrence_counter_defines.svh"

module mpoc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         full,
	input logic                         empty,
	input logic                         pop,
	input logic [mpoc_pkg::COUNT_W-1:0] count,
	input logic [mpoc_pkg::PID_W-1:0]   pattern_echo,
	input logic [mpoc_pkg::ST_W-1:0]    status
);

	import mpoc_pkg::*;

	// Only a successful read carries a nonzero count.
	`MPOC_ASSERT_SAME(a_count_only_ok, clk, arst_n, !empty && (count != '0), status == ST_OK, "nonzero count with error status")

	// The memory sweep after reset holds off new transactions.
	`MPOC_ASSERT_SAME(a_clear_blocks, clk, arst_n, !$past(arst_n), full, "input taken during clearing pass")

	// A waiting result holds until it is taken.
	`MPOC_ASSERT_NEXT(a_result_holds, clk, arst_n, !empty && !pop, !empty && $stable(count) && $stable(status) && $stable(pattern_echo), "waiting result changed")

endmodule

bind multi_pattern_occurrence_counter mpoc_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.full        (full),
	.empty       (empty),
	.pop         (pop),
	.count       (count),
	.pattern_echo(pattern_echo),
	.status      (status)
);

`default_nettype wire
